[rtl/ppe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ppe_pkg;
  localparam int SegmentsMaxDef = 16;
  localparam int PolyOrderDef   = 5;
  localparam int TimeW  = 24;
  localparam int DataW  = 32;
  localparam int AccW   = 40;
  localparam int CountW = 5;

  typedef enum logic [1:0] {
    REQ_TIME = 2'd0,
    REQ_COEF = 2'd1,
    REQ_EVAL = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [3:0]        seg_index;
    logic [2:0]        coef_index;
    logic [1:0]        axis;
    logic signed [31:0] load_value;
    logic [23:0]       query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic              past_end;
  } out_item_t;
endpackage
`default_nettype wire

[rtl/ppe_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ppe_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/piecewise_poly_pva_eval_unit.sv]
// piecewise polynomial evaluator: position, velocity, acceleration on three axes
// in channel: one item per transfer; load time, load coefficient or evaluate
// loads give no result; req_type 3 is dropped
// evaluate: scan of the boundary table, one entry a cycle (up to SEGMENTS_MAX),
// then 3 axes x 3 derivatives, each a Horner chain on one shared two-stage
// multiply-accumulate unit, each step going through memory read, mult and add states
// a query past the last boundary ends the scan in its first state; the past-end
// result, all values zero, is registered there and no Horner chain runs
// one evaluate at a time: in_ready is low from acceptance until the result transfer
// out channel holds its result until out_ready; a stalled result blocks input
// cfg_we writes segment_count (5 bits); 0 acts as 1, large values clamp
// reset sets segment_count to 1 and returns to idle; tables are not cleared
`timescale 1ns / 1ps
`default_nettype none
module piecewise_poly_pva_eval_unit import ppe_pkg::*; #(
  parameter int SEGMENTS_MAX = SegmentsMaxDef,
  parameter int POLY_ORDER   = PolyOrderDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  ppe_stream_if.sink               in_ch,
  ppe_stream_if.source             out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CountW-1:0]   cfg_wdata
);
  localparam int Rows   = POLY_ORDER + 1;
  localparam int Depth  = SEGMENTS_MAX * Rows * 3;
  localparam int SegW   = (SEGMENTS_MAX > 1) ? $clog2(SEGMENTS_MAX) : 1;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RowW   = $clog2(Rows + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_MUL, S_ADD, S_NEXT, S_OUT} state_t;

  logic [TimeW-1:0]  times_mem [SEGMENTS_MAX];
  logic [DataW-1:0]  coef_mem  [Depth];

  state_t            state_r;
  logic [CountW-1:0] count_r;
  logic [TimeW-1:0]  q_r, start_r, t_r;
  logic [SegW:0]     scan_r;
  logic [SegW-1:0]   sel_r;
  logic [1:0]        ax_r, d_r;
  logic [RowW-1:0]   row_r;
  logic signed [AccW-1:0] acc_r;
  logic [DataW-1:0]  coef_q_r;
  logic [TimeW-1:0]  tq_r;
  logic [DataW*9-1:0] res_r;
  logic              past_r;
  logic              out_valid_r;

  logic [SegW:0]     cnt_eff;
  logic [SegW-1:0]   last_idx, seg_in, scan_idx;
  logic              load_ok;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [5:0]        weight;
  logic [3:0]        pw;
  logic              mac_v;
  logic signed [AccW-1:0] mac_out;
  logic signed [DataW-1:0] sat_val;
  logic              accept;
  logic [3:0]        res_idx;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    if (count_r == '0) cnt_eff = (SegW+1)'(1);
    else if (32'(count_r) > SEGMENTS_MAX) cnt_eff = (SegW+1)'(SEGMENTS_MAX);
    else cnt_eff = (SegW+1)'(count_r);
    last_idx = SegW'(cnt_eff - 1'b1);
    seg_in   = SegW'(in_ch.data.seg_index);
    scan_idx = SegW'(scan_r);
    load_ok  = (32'(in_ch.data.seg_index) < SEGMENTS_MAX)
            && (32'(in_ch.data.coef_index) <= POLY_ORDER) && (in_ch.data.axis != 2'd3);
    wr_addr  = AddrW'((32'(in_ch.data.seg_index) * Rows + 32'(in_ch.data.coef_index)) * 3
                      + 32'(in_ch.data.axis));
    rd_addr  = AddrW'((32'(sel_r) * Rows + 32'(row_r)) * 3 + 32'(ax_r));
    pw       = 4'(POLY_ORDER - 32'(row_r));
    unique case (d_r)
      2'd0:    weight = 6'd1;
      2'd1:    weight = 6'(pw);
      default: weight = 6'(pw) * (6'(pw) - 6'd1);
    endcase
    if (mac_out > 40'sh007FFFFFFF) sat_val = 32'sh7FFFFFFF;
    else if (mac_out < -40'sh0080000000) sat_val = -32'sh80000000;
    else sat_val = DataW'(mac_out);
    res_idx = 4'(d_r) * 4'd3 + 4'(ax_r);
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.data.req_type == REQ_TIME && 32'(in_ch.data.seg_index) < SEGMENTS_MAX)
      times_mem[seg_in] <= in_ch.data.load_value[TimeW-1:0];
    if (accept && in_ch.data.req_type == REQ_COEF && load_ok)
      coef_mem[wr_addr] <= in_ch.data.load_value;
    coef_q_r <= coef_mem[rd_addr];
    tq_r     <= times_mem[(state_r == S_IDLE) ? last_idx : scan_idx];
  end

  ppe_mac u_mac (
    .clk(clk), .start(state_r == S_MUL), .first(row_r == '0),
    .acc_in(acc_r), .t(t_r), .coef(coef_q_r), .weight(weight),
    .prod_valid(mac_v), .acc_out(mac_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CountW'(1);
      out_valid_r <= 1'b0;
      past_r <= 1'b0;
    end else begin
      if (cfg_we) count_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept && in_ch.data.req_type == REQ_EVAL) begin
          q_r <= in_ch.data.query_time;
          scan_r <= '0; sel_r <= '0; start_r <= '0;
          past_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // first cycle: tq_r holds last entry for past-end check
          if (scan_r == '0 && !past_r && q_r > tq_r) begin
            res_r <= '0; past_r <= 1'b1; out_valid_r <= 1'b1; state_r <= S_IDLE;
          end else if (scan_r == '0 && !past_r) begin
            past_r <= 1'b1; scan_r <= '0;
          end else begin
            if (scan_r != '0 && tq_r < q_r) begin
              start_r <= tq_r; sel_r <= SegW'(scan_r - 1'b1);
            end
            if (scan_r == cnt_eff || (scan_r != '0 && !(tq_r < q_r))) begin
              past_r <= 1'b0; state_r <= S_NEXT;
              d_r <= '0; ax_r <= '0; row_r <= '0;
            end else scan_r <= scan_r + 1'b1;
          end
        end
        S_NEXT: begin
          t_r <= q_r - start_r;
          state_r <= S_RD;
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: state_r <= S_ADD;
        S_ADD: if (mac_v) begin
          if (32'(row_r) == POLY_ORDER - 32'(d_r)) begin
            res_r[DataW*(8-32'(res_idx)) +: DataW] <= sat_val;
            row_r <= '0;
            if (ax_r == 2'd2) begin
              ax_r <= '0;
              if (d_r == 2'd2) begin
                out_valid_r <= 1'b1; state_r <= S_IDLE;
              end else begin
                d_r <= d_r + 1'b1; state_r <= S_RD;
              end
            end else begin
              ax_r <= ax_r + 1'b1; state_r <= S_RD;
            end
          end else begin
            row_r <= row_r + 1'b1; state_r <= S_RD;
          end
          acc_r <= mac_out;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  always_comb begin
    out_ch.data = '0;
    {out_ch.data.pos_x, out_ch.data.pos_y, out_ch.data.pos_z,
     out_ch.data.vel_x, out_ch.data.vel_y, out_ch.data.vel_z,
     out_ch.data.acc_x, out_ch.data.acc_y, out_ch.data.acc_z} = res_r;
    out_ch.data.past_end = past_r;
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ch.ready) else $error("accept with result pending");
endmodule
`default_nettype wire

[rtl/ppe_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
module ppe_mac import ppe_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   start,
  input  wire logic                   first,
  input  wire logic signed [AccW-1:0] acc_in,
  input  wire logic [TimeW-1:0]       t,
  input  wire logic signed [DataW-1:0] coef,
  input  wire logic [5:0]             weight,
  output logic                        prod_valid,
  output logic signed [AccW-1:0]      acc_out
);
  // stage 1: acc*t and c*w registered; stage 2: round, add, saturate
  logic signed [AccW+TimeW:0]  prod_r;
  logic signed [DataW+6:0]     cw_r;
  logic                        first_r;
  logic signed [AccW+TimeW+1:0] sum;
  logic signed [AccW+TimeW+1:0] amax, amin;

  always_ff @(posedge clk) begin
    prod_r     <= acc_in * $signed({1'b0, t});
    cw_r       <= coef * $signed({1'b0, weight});
    first_r    <= first;
    prod_valid <= start;
  end

  always_comb begin
    amax = (AccW+TimeW+2)'((64'sd1 <<< (AccW-1)) - 1);
    amin = -amax - 1;
    if (first_r) sum = (AccW+TimeW+2)'(cw_r);
    else sum = ((AccW+TimeW+2)'(prod_r) + 32768) >>> 16;
    if (!first_r) sum = sum + (AccW+TimeW+2)'(cw_r);
    if (sum > amax) acc_out = AccW'(amax);
    else if (sum < amin) acc_out = AccW'(amin);
    else acc_out = AccW'(sum);
  end
endmodule
`default_nettype wire

[tb/sv/tb_piecewise_poly_pva_eval_unit.sv]
`timescale 1ns / 1ps
module tb_piecewise_poly_pva_eval_unit;
  import ppe_pkg::*;

  localparam int NumSeg = 16;
  localparam int NumRow = 6;
  localparam int IdleLimit = 5000;
  localparam int SettleCycles = 200;
  localparam int LongHold = 400;
  localparam longint AccMax = (64'sd1 <<< 39) - 1;
  localparam longint AccMin = -(64'sd1 <<< 39);

  typedef struct {
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;

  ppe_stream_if #(.payload_t(in_item_t)) in_ch();
  ppe_stream_if #(.payload_t(out_item_t)) out_ch();

  piecewise_poly_pva_eval_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [23:0]        bnd_time[NumSeg];
  logic signed [31:0] coef_tab[NumSeg*NumRow*3];
  logic [CountW-1:0]  seg_count;

  out_item_t expected_pva[$];
  int errors = 0;
  int n_eval = 0;
  int n_past = 0;
  int n_load = 0;
  int n_cfg = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic longint sat40(longint x);
    if (x > AccMax) return AccMax;
    if (x < AccMin) return AccMin;
    return x;
  endfunction

  function automatic logic signed [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic longint horner_eval(int seg, int ax, int d, longint t);
    longint acc;
    longint c;
    longint w;
    bit first;
    acc = 0;
    first = 1'b1;
    for (int p = 5; p >= d; p--) begin
      w = (d == 0) ? 1 : (d == 1) ? p : p * (p - 1);
      c = longint'(coef_tab[(seg * NumRow + (5 - p)) * 3 + ax]) * w;
      if (first) begin
        acc = sat40(c);
        first = 1'b0;
      end else begin
        acc = sat40(((acc * t + 32768) >>> 16) + c);
      end
    end
    return acc;
  endfunction

  function automatic int eff_count();
    if (seg_count == 0) return 1;
    if (seg_count > NumSeg) return NumSeg;
    return seg_count;
  endfunction

  // updates the table copy and returns 1 when the item gives a result
  function automatic bit predict_pva(in_item_t it, output out_item_t o);
    int cnt;
    int sel;
    logic [23:0] start;
    longint t;
    logic signed [31:0] v[9];
    o = '0;
    case (req_t'(it.req_type))
      REQ_TIME: begin
        bnd_time[it.seg_index] = it.load_value[23:0];
        return 1'b0;
      end
      REQ_COEF: begin
        if (it.coef_index <= 5 && it.axis < 3)
          coef_tab[(it.seg_index * NumRow + it.coef_index) * 3 + it.axis] = it.load_value;
        return 1'b0;
      end
      REQ_EVAL: begin
        cnt = eff_count();
        if (it.query_time > bnd_time[cnt - 1]) begin
          o.past_end = 1'b1;
          return 1'b1;
        end
        sel = 0;
        start = '0;
        for (int m = 0; m < cnt; m++) begin
          if (bnd_time[m] < it.query_time) begin
            start = bnd_time[m];
            sel = m;
          end else begin
            break;
          end
        end
        t = longint'(it.query_time - start);
        for (int d = 0; d < 3; d++)
          for (int a = 0; a < 3; a++)
            v[d * 3 + a] = sat32(horner_eval(sel, a, d, t));
        o.pos_x = v[0]; o.pos_y = v[1]; o.pos_z = v[2];
        o.vel_x = v[3]; o.vel_y = v[4]; o.vel_z = v[5];
        o.acc_x = v[6]; o.acc_y = v[7]; o.acc_z = v[8];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_pva.size() == 0) begin
      report_mismatch("result with nothing expected", got.pos_x, 0);
      return;
    end
    want = expected_pva.pop_front();
    check_field("pos_x", got.pos_x, want.pos_x);
    check_field("pos_y", got.pos_y, want.pos_y);
    check_field("pos_z", got.pos_z, want.pos_z);
    check_field("vel_x", got.vel_x, want.vel_x);
    check_field("vel_y", got.vel_y, want.vel_y);
    check_field("vel_z", got.vel_z, want.vel_z);
    check_field("acc_x", got.acc_x, want.acc_x);
    check_field("acc_y", got.acc_y, want.acc_y);
    check_field("acc_z", got.acc_z, want.acc_z);
    if (got.past_end !== want.past_end) report_mismatch("past_end", got.past_end, want.past_end);
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (hold_request) begin
        hold = LongHold;
        hold_request = 1'b0;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("timeout with %0d results outstanding", expected_pva.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    out_item_t o;
    out_item_t exp_item;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_pva(it, o)) begin
      exp_item = typed ? want : o;
      expected_pva.insert(expected_pva.size(), exp_item);
      n_eval++;
      if (o.past_end) n_past++;
    end else if (req_t'(it.req_type) != REQ_NONE) begin
      n_load++;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_pva.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_count(logic [CountW-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    seg_count = v;
    n_cfg++;
  endtask

  function automatic in_item_t mk(req_t r, int seg, int row, int ax, logic [31:0] val,
                                  logic [23:0] q);
    in_item_t it;
    it.req_type = r;
    it.seg_index = seg;
    it.coef_index = row;
    it.axis = ax;
    it.load_value = val;
    it.query_time = q;
    return it;
  endfunction

  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
    if (r < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      default: return 32'h0;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    int r;
    int cnt;
    int j;
    logic [23:0] q;
    logic [23:0] last;
    r = $urandom_range(0, 99);
    cnt = eff_count();
    last = bnd_time[cnt - 1];
    if (r < 8) begin
      j = $urandom_range(0, NumSeg - 1);
      if ($urandom_range(0, 9) < 7)
        return mk(REQ_TIME, j, $urandom_range(0, 7), $urandom_range(0, 3),
                  {8'($urandom), 24'(j * 32'h20000 + $urandom_range(0, 32'h1ffff))}, $urandom);
      return mk(REQ_TIME, j, $urandom_range(0, 7), $urandom_range(0, 3), $urandom, $urandom);
    end
    if (r < 30) begin
      if ($urandom_range(0, 9) == 0)
        return mk(REQ_COEF, $urandom_range(0, 15), $urandom_range(6, 7), $urandom_range(0, 3),
                  $urandom, $urandom);
      if ($urandom_range(0, 9) == 0)
        return mk(REQ_COEF, $urandom_range(0, 15), $urandom_range(0, 5), 3, $urandom, $urandom);
      return mk(REQ_COEF, $urandom_range(0, 15), $urandom_range(0, 5), $urandom_range(0, 2),
                rand_coef(), $urandom);
    end
    if (r < 33) return mk(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    r = $urandom_range(0, 99);
    if (r < 15) begin
      q = $urandom;
    end else if (r < 50) begin
      q = bnd_time[$urandom_range(0, cnt - 1)];
      case ($urandom_range(0, 2))
        0: q = (q == 0) ? q : q - 1;
        1: q = (q == 24'hffffff) ? q : q + 1;
        default: ;
      endcase
    end else begin
      q = $urandom_range(0, last);
    end
    return mk(REQ_EVAL, $urandom, $urandom, $urandom, $urandom, q);
  endfunction

  task automatic run_random(int n);
    in_item_t it;
    int sent;
    sent = 0;
    while (sent < n) begin
      it = rand_item();
      send_item(it, 1'b0, '0);
      if (req_t'(it.req_type) != REQ_NONE) sent++;
    end
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t rw;
    out_item_t past;
    int counts[$];

    for (int i = 0; i < NumSeg; i++) bnd_time[i] = '0;
    for (int i = 0; i < NumSeg * NumRow * 3; i++) coef_tab[i] = '0;
    seg_count = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every table entry so that no evaluate reads an unwritten one
    for (int s = 0; s < NumSeg; s++)
      send_item(mk(REQ_TIME, s, 0, 0, s * 32'h20000 + $urandom_range(0, 32'h1ffff), 0),
                1'b0, '0);
    for (int s = 0; s < NumSeg; s++)
      for (int r = 0; r < NumRow; r++)
        for (int a = 0; a < 3; a++)
          send_item(mk(REQ_COEF, s, r, a, rand_coef(), 0), 1'b0, '0);

    past = '0;
    past.past_end = 1'b1;
    rw.typed = 1'b0;
    rw.want = '0;
    rw.item = mk(REQ_TIME, 0, 0, 0, 32'hab010000, 24'hffffff); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_EVAL, 0, 0, 0, 0, 24'hffffff); rw.typed = 1'b1; rw.want = past;
    rows.insert(rows.size(), rw);
    rw.item = mk(REQ_EVAL, 15, 7, 3, 32'hffffffff, 24'h010001); rows.insert(rows.size(), rw);
    rw.typed = 1'b0; rw.want = '0;
    rw.item = mk(REQ_EVAL, 0, 0, 0, 0, 24'h010000); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_EVAL, 0, 0, 0, 0, 24'h000000); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 5, 0, 32'h7fffffff, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 5, 1, 32'h80000000, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 4, 2, 32'h7fffffff, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 3, 0, 32'h80000000, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_EVAL, 0, 0, 0, 0, 24'h000000); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 6, 0, 32'h12345678, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 7, 1, 32'h12345678, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 0, 3, 32'h12345678, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_NONE, 15, 7, 3, 32'hffffffff, 24'hffffff); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 0, 0, 32'h7fffffff, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 0, 1, 32'h80000000, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 0, 0, 2, 32'h7fffffff, 0); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_EVAL, 0, 0, 0, 0, 24'h010000); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_EVAL, 0, 0, 0, 0, 24'h008000); rows.insert(rows.size(), rw);
    rw.item = mk(REQ_COEF, 15, 5, 2, 32'h00010000, 0); rows.insert(rows.size(), rw);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    counts = '{16, 1, 0, 31, 17, 8, 2};
    foreach (counts[i]) begin
      write_count(CountW'(counts[i]));
      quiet = (i == 3);
      if (i == 1) hold_request = 1'b1;
      run_random(100);
      if (i == 2) begin
        wait_drained();
        run_random(40);
      end
    end
    quiet = 1'b0;
    for (int i = 0; i < 3; i++) begin
      write_count(CountW'($urandom));
      run_random(100);
    end

    wait_drained();
    $display("%0d loads, %0d evaluates (%0d past the end), %0d count writes",
             n_load, n_eval, n_past, n_cfg);
    $display("counts covered 0, 1, 2, 8, 16, 17, 31 and random, with a long result hold");
    if (errors == 0 && expected_pva.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/ppe_pkg.sv
rtl/ppe_stream_if.sv
rtl/ppe_mac.sv
rtl/piecewise_poly_pva_eval_unit.sv
tb/sv/tb_piecewise_poly_pva_eval_unit.sv
